>>> hw/rtl/ffra_pkg.sv
// Package for the first-fit region allocator.
// Table sizes, widths, command and status codes, beat structs. No dependencies.
package ffra_pkg;
	localparam int FREE_ENTRIES  = 32;
	localparam int ALLOC_ENTRIES = 32;
	localparam int PAGE_W        = 30;
	localparam int FIDX_W        = $clog2(FREE_ENTRIES);
	localparam int FCNT_W        = $clog2(FREE_ENTRIES + 1);
	localparam int AIDX_W        = $clog2(ALLOC_ENTRIES);
	localparam int CFG_W         = 30;
	localparam int START_REG_W   = 29;
	localparam int COUNT_REG_W   = 30;
	localparam logic [PAGE_W-1:0] PAGE_MASK = '1;
	localparam logic [START_REG_W-1:0] START_RESET = START_REG_W'(268435456);
	localparam logic [COUNT_REG_W-1:0] COUNT_RESET = COUNT_REG_W'(268435456);

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_NOT_FND  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_OVERLAP  = 3'd4;

	localparam logic REG_POOL_START = 1'b0;
	localparam logic REG_POOL_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [PAGE_W-1:0] length_pages;
		logic [PAGE_W-1:0] region_page;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [PAGE_W-1:0] start_page;
		logic [PAGE_W-1:0] region_pages;
	} result_t;

	// One table entry: a free region [lo, hi) or an allocation (start, length)
	typedef struct packed {
		logic [PAGE_W-1:0] lo;
		logic [PAGE_W-1:0] hi;
	} entry_t;
endpackage

>>> hw/rtl/ffra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/first_fit_region_allocator_top.sv
// First-fit region allocator top level: sequencer around the free and allocation tables.
// Depends on ffra_pkg and ffra_ram.
//
// Usage: raise start with a command while busy is low. One result beat per command
// appears on result with done high for a single cycle and cannot be held off.
// Each table access presents the address, then uses the registered read data. An
// allocate inspects free entries in turn and shifts entries down when a region is
// used up; a free searches the allocation slots, walks the free entries before the
// insertion point and shifts entries. After reset the block writes the initial free
// region before busy falls. Register writes take effect at the next reinitialize.
module first_fit_region_allocator_top
	import ffra_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               done,
	output result_t            result,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);
	typedef enum logic [11:0] {
		S_INIT = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_ARD  = 12'b000000000100,
		S_ACHK = 12'b000000001000,
		S_SRD  = 12'b000000010000,
		S_SCHK = 12'b000000100000,
		S_IRD  = 12'b000001000000,
		S_ICHK = 12'b000010000000,
		S_IDEC = 12'b000100000000,
		S_MRD  = 12'b001000000000,
		S_MWR  = 12'b010000000000,
		S_PUT  = 12'b100000000000
	} state_t;

	state_t                   state_q;
	logic [START_REG_W-1:0]   pool_start_q;
	logic [COUNT_REG_W-1:0]   pool_count_q;
	logic [FCNT_W-1:0]        count_q;
	logic [ALLOC_ENTRIES-1:0] valid_q;
	logic [PAGE_W-1:0]        len_q, page_q, reg_s_q, reg_e_q;
	entry_t                   prev_q, cur_q;
	logic [FCNT_W-1:0]        scan_q;
	logic [FIDX_W-1:0]        j_q;
	logic [AIDX_W-1:0]        slot_q;
	logic                     up_q, is_free_q, cmd_init_q;
	logic                     done_q;
	result_t                  res_q;

	// table ports
	logic             fr_we, al_we;
	logic [FIDX_W-1:0] fr_waddr, fr_raddr;
	entry_t           fr_wdata, fr_rdata, al_wdata, al_rdata;
	logic [AIDX_W-1:0] al_waddr;

	ffra_ram #(.WIDTH(2*PAGE_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	ffra_ram #(.WIDTH(2*PAGE_W), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(slot_q), .rdata(al_rdata)
	);

	// lowest free allocation slot
	logic [AIDX_W-1:0] free_slot;
	logic              slot_ok;
	always_comb begin
		free_slot = '0;
		for (int k = ALLOC_ENTRIES - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_slot = AIDX_W'(k);
			end
		end
		slot_ok = ~&valid_q;
	end

	// pool window from registers, end saturated
	logic [PAGE_W:0]   pool_sum;
	logic [PAGE_W-1:0] pool_s, pool_e;
	logic              pool_nonempty;
	always_comb begin
		pool_s        = PAGE_W'(pool_start_q);
		pool_sum      = {1'b0, pool_s} + (PAGE_W+1)'(pool_count_q);
		pool_e        = (pool_sum > {1'b0, PAGE_MASK}) ? PAGE_MASK : pool_sum[PAGE_W-1:0];
		pool_nonempty = pool_e > pool_s;
	end

	// decode helpers
	logic [PAGE_W-1:0] fr_size;
	logic [FCNT_W-1:0] scan_nx;
	logic              has_prev, has_next, join_prev, join_next, overlap;
	logic [FIDX_W-1:0] scan_idx, scan_m1;
	always_comb begin
		fr_size   = fr_rdata.hi - fr_rdata.lo;
		scan_nx   = scan_q + FCNT_W'(1);
		scan_idx  = scan_q[FIDX_W-1:0];
		scan_m1   = scan_idx - FIDX_W'(1);
		has_prev  = scan_q != '0;
		has_next  = scan_q < count_q;
		overlap   = has_prev && (reg_s_q < prev_q.hi);
		join_prev = has_prev && (prev_q.hi == reg_s_q);
		join_next = has_next && (cur_q.lo == reg_e_q);
	end

	// table write and read addressing per state
	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = '0;
		fr_wdata = '0;
		fr_raddr = scan_idx;
		al_we    = 1'b0;
		al_waddr = free_slot;
		al_wdata = '{lo: fr_rdata.lo, hi: len_q};
		case (state_q)
			S_INIT: begin
				fr_we    = pool_nonempty;
				fr_wdata = '{lo: pool_s, hi: pool_e};
			end
			S_ACHK: begin
				if (fr_size >= len_q && slot_ok) begin
					al_we = 1'b1;
					if (fr_size > len_q) begin
						fr_we    = 1'b1;
						fr_waddr = scan_idx;
						fr_wdata = '{lo: fr_rdata.lo + len_q, hi: fr_rdata.hi};
					end
				end
			end
			S_IDEC: begin
				if (!overlap) begin
					if (join_prev) begin
						fr_we    = 1'b1;
						fr_waddr = scan_m1;
						fr_wdata = '{lo: prev_q.lo, hi: join_next ? cur_q.hi : reg_e_q};
					end else if (join_next) begin
						fr_we    = 1'b1;
						fr_waddr = scan_idx;
						fr_wdata = '{lo: reg_s_q, hi: cur_q.hi};
					end else if (count_q == scan_q) begin
						fr_we    = count_q != FCNT_W'(FREE_ENTRIES);
						fr_waddr = scan_idx;
						fr_wdata = '{lo: reg_s_q, hi: reg_e_q};
					end
				end
			end
			S_MRD: begin
				fr_raddr = up_q ? (j_q - FIDX_W'(1)) : (j_q + FIDX_W'(1));
			end
			S_MWR: begin
				fr_we    = 1'b1;
				fr_waddr = j_q;
				fr_wdata = fr_rdata;
			end
			S_PUT: begin
				fr_we    = 1'b1;
				fr_waddr = scan_idx;
				fr_wdata = '{lo: reg_s_q, hi: reg_e_q};
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_start_q <= START_RESET;
			pool_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_POOL_START) begin
				pool_start_q <= cfg_data[START_REG_W-1:0];
			end else begin
				pool_count_q <= cfg_data[COUNT_REG_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			count_q    <= '0;
			valid_q    <= '0;
			done_q     <= 1'b0;
			cmd_init_q <= 1'b0;
			is_free_q  <= 1'b0;
			up_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					valid_q <= '0;
					count_q <= pool_nonempty ? FCNT_W'(1) : '0;
					if (cmd_init_q) begin
						done_q <= 1'b1;
						res_q  <= '{status: ST_OK,
							start_page: pool_nonempty ? pool_s : '0,
							region_pages: pool_nonempty ? (pool_e - pool_s) : '0};
					end
					cmd_init_q <= 1'b0;
					state_q    <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						len_q     <= cmd.length_pages;
						page_q    <= cmd.region_page;
						scan_q    <= '0;
						slot_q    <= '0;
						is_free_q <= cmd.action == ACT_FREE;
						case (action_t'(cmd.action))
							ACT_ALLOC: begin
								if (cmd.length_pages == '0 || count_q == '0) begin
									done_q  <= 1'b1;
									res_q   <= '{status: ST_NO_SPACE, default: '0};
								end else begin
									state_q <= S_ARD;
								end
							end
							ACT_FREE: state_q <= S_SRD;
							ACT_INIT: begin
								cmd_init_q <= 1'b1;
								state_q    <= S_INIT;
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '{status: ST_OK, default: '0};
							end
						endcase
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (fr_size >= len_q) begin
						if (!slot_ok) begin
							done_q  <= 1'b1;
							res_q   <= '{status: ST_FULL, default: '0};
							state_q <= S_IDLE;
						end else begin
							valid_q[free_slot] <= 1'b1;
							res_q <= '{status: ST_OK, start_page: fr_rdata.lo,
								region_pages: len_q};
							if (fr_size > len_q || scan_nx == count_q) begin
								// shrink in place, or drop the last entry
								if (fr_size == len_q) begin
									count_q <= count_q - FCNT_W'(1);
								end
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								j_q     <= scan_idx;
								up_q    <= 1'b0;
								state_q <= S_MRD;
							end
						end
					end else if (scan_nx == count_q) begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_NO_SPACE, default: '0};
						state_q <= S_IDLE;
					end else begin
						scan_q  <= scan_nx;
						state_q <= S_ARD;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (valid_q[slot_q] && al_rdata.lo == page_q) begin
						reg_s_q <= al_rdata.lo;
						reg_e_q <= al_rdata.lo + al_rdata.hi;
						res_q   <= '{status: ST_OK, start_page: al_rdata.lo,
							region_pages: al_rdata.hi};
						state_q <= (count_q == '0) ? S_IDEC : S_IRD;
					end else if (slot_q == AIDX_W'(ALLOC_ENTRIES - 1)) begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_NOT_FND, default: '0};
						state_q <= S_IDLE;
					end else begin
						slot_q  <= slot_q + AIDX_W'(1);
						state_q <= S_SRD;
					end
				end
				S_IRD: state_q <= S_ICHK;
				S_ICHK: begin
					if (fr_rdata.lo < reg_e_q) begin
						prev_q  <= fr_rdata;
						scan_q  <= scan_nx;
						state_q <= (scan_nx == count_q) ? S_IDEC : S_IRD;
					end else begin
						cur_q   <= fr_rdata;
						state_q <= S_IDEC;
					end
				end
				S_IDEC: begin
					state_q <= S_IDLE;
					if (overlap) begin
						done_q       <= 1'b1;
						res_q.status <= ST_OVERLAP;
					end else if (join_prev && join_next) begin
						if (scan_nx < count_q) begin
							j_q     <= scan_idx;
							up_q    <= 1'b0;
							state_q <= S_MRD;
						end else begin
							count_q          <= count_q - FCNT_W'(1);
							valid_q[slot_q]  <= 1'b0;
							done_q           <= 1'b1;
						end
					end else if (join_prev || join_next) begin
						valid_q[slot_q] <= 1'b0;
						done_q          <= 1'b1;
					end else if (count_q == FCNT_W'(FREE_ENTRIES)) begin
						done_q       <= 1'b1;
						res_q.status <= ST_FULL;
					end else if (count_q == scan_q) begin
						count_q         <= count_q + FCNT_W'(1);
						valid_q[slot_q] <= 1'b0;
						done_q          <= 1'b1;
					end else begin
						j_q     <= count_q[FIDX_W-1:0];
						up_q    <= 1'b1;
						state_q <= S_MRD;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					if (up_q) begin
						j_q     <= j_q - FIDX_W'(1);
						state_q <= ((j_q - FIDX_W'(1)) == scan_idx) ? S_PUT : S_MRD;
					end else begin
						j_q <= j_q + FIDX_W'(1);
						if ((FCNT_W'(j_q) + FCNT_W'(2)) == count_q) begin
							// last entry moved down: table shrinks by one
							count_q <= count_q - FCNT_W'(1);
							if (is_free_q) begin
								valid_q[slot_q] <= 1'b0;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MRD;
						end
					end
				end
				S_PUT: begin
					count_q         <= count_q + FCNT_W'(1);
					valid_q[slot_q] <= 1'b0;
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;
endmodule

>>> hw/rtl/ffra_checker.sv
// Port-level checker for the first-fit region allocator, bound to the top level.
// Depends on ffra_pkg.
module ffra_checker
	import ffra_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);
	// a result beat only follows a command in flight
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result beat with no command");

	// status codes stay in the defined set
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_NO_SPACE ||
			result.status == ST_NOT_FND || result.status == ST_FULL ||
			result.status == ST_OVERLAP))
		else $error("status code out of range");

	// failed lookups and allocations with no space report an empty region
	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_NOT_FND || result.status == ST_NO_SPACE)
		|-> result.start_page == '0 && result.region_pages == '0)
		else $error("failed beat carries a region");

	// an overlap report names a non-empty allocation
	a_overlap_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_OVERLAP |-> result.region_pages != '0)
		else $error("overlap beat with empty region");
endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result)
);
